### rtl/ppq_pkg.sv
`default_nettype none

package ppq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_PACKET  = 64;
  localparam int MAC_BYTES   = 6;

  localparam int MAC_W  = 8 * MAC_BYTES;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int LEN_W  = $clog2(MAX_PACKET + 1);
  localparam int ADDR_W = $clog2(QUEUE_DEPTH * MAX_PACKET);

  // item kinds
  localparam logic [2:0] KIND_NORMAL   = 3'd0;
  localparam logic [2:0] KIND_PRIORITY = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
  localparam logic [2:0] KIND_PURGE    = 3'd3;
  localparam logic [2:0] KIND_SEND     = 3'd4;

  // result kinds
  localparam logic RKIND_STATUS = 1'b0;
  localparam logic RKIND_BYTE   = 1'b1;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       station_id;
    logic [MAC_W-1:0] mac_address;
    logic [9:0]       packet_length;
    logic [7:0]       payload_byte;
    logic             link_ready;
  } item_t;

  typedef struct packed {
    logic             result_kind;
    logic             accepted;
    logic [7:0]       out_station;
    logic [MAC_W-1:0] out_mac;
    logic [7:0]       out_byte;
    logic             last_byte;
    logic [3:0]       entries_held;
  } res_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [MAC_W-1:0] mac;
    logic [7:0]       station;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    res = (idx == '0) ? IDX_W'(QUEUE_DEPTH - 1) : idx - 1'b1;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] pay_addr(input logic [IDX_W-1:0] phys,
                                                 input logic [LEN_W-1:0] pos);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(phys) * ADDR_W'(MAX_PACKET) + ADDR_W'(pos);
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/ppq_ram.sv
`default_nettype none

module ppq_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/ppq_ctrl.sv
`default_nettype none

module ppq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ppq_pkg::item_t                in_item,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output ppq_pkg::res_t                      res,
  output logic                               meta_we,
  output logic [ppq_pkg::IDX_W-1:0]          meta_waddr,
  output ppq_pkg::meta_t                     meta_wdata,
  output logic                               meta_re,
  output logic [ppq_pkg::IDX_W-1:0]          meta_raddr,
  input  wire ppq_pkg::meta_t                meta_rdata,
  output logic                               pay_we,
  output logic [ppq_pkg::ADDR_W-1:0]         pay_waddr,
  output logic [7:0]                         pay_wdata,
  output logic                               pay_re,
  output logic [ppq_pkg::ADDR_W-1:0]         pay_raddr,
  input  wire logic [7:0]                    pay_rdata
);

  import ppq_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RESP   = 3'd1;
  localparam logic [2:0] ST_P_RD   = 3'd2;
  localparam logic [2:0] ST_P_CMP  = 3'd3;
  localparam logic [2:0] ST_S_META = 3'd4;
  localparam logic [2:0] ST_S_RD   = 3'd5;
  localparam logic [2:0] ST_S_OUT  = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [QUEUE_DEPTH-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]       fill_phys_r, fill_phys_nxt;
  logic [LEN_W-1:0]       fill_pos_r, fill_pos_nxt;
  logic [LEN_W-1:0]       fill_left_r, fill_left_nxt;
  logic                   acc_r, acc_nxt;
  logic [7:0]             pst_r, pst_nxt;
  logic [CNT_W-1:0]       pi_r, pi_nxt;
  logic [CNT_W-1:0]       kept_r, kept_nxt;
  logic [IDX_W-1:0]       cur_phys_r, cur_phys_nxt;
  logic [7:0]             tx_st_r, tx_st_nxt;
  logic [MAC_W-1:0]       tx_mac_r, tx_mac_nxt;
  logic [LEN_W-1:0]       tx_len_r, tx_len_nxt;
  logic [LEN_W-1:0]       tx_j_r, tx_j_nxt;

  // logical ring of physical slot numbers
  logic [IDX_W-1:0] order_r [QUEUE_DEPTH];
  logic             ord_we;
  logic [IDX_W-1:0] ord_waddr;
  logic [IDX_W-1:0] ord_wdata;
  logic [IDX_W-1:0] ord_raddr;
  logic [IDX_W-1:0] ord_rd;

  logic [IDX_W-1:0] free_idx;
  logic             head_busy;
  logic             accept;
  logic             hdr_ok;
  logic             res_taken;
  logic             tx_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_RESP) || (state_r == ST_S_OUT);
  assign res_taken = res_valid && res_ready;
  assign tx_last   = (tx_j_r == tx_len_r - 1'b1);

  assign ord_raddr = (state_r == ST_P_RD) ? ring_add(head_r, pi_r) : head_r;
  assign ord_rd    = order_r[ord_raddr];
  assign head_busy = (fill_left_r != '0) && (fill_phys_r == ord_rd);

  assign hdr_ok = (in_item.packet_length != '0) &&
                  (in_item.packet_length <= 10'(MAX_PACKET)) &&
                  (count_r < CNT_W'(QUEUE_DEPTH)) &&
                  (fill_left_r == '0);

  // lowest free physical slot
  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    fill_phys_nxt = fill_phys_r;
    fill_pos_nxt  = fill_pos_r;
    fill_left_nxt = fill_left_r;
    acc_nxt       = acc_r;
    pst_nxt       = pst_r;
    pi_nxt        = pi_r;
    kept_nxt      = kept_r;
    cur_phys_nxt  = cur_phys_r;
    tx_st_nxt     = tx_st_r;
    tx_mac_nxt    = tx_mac_r;
    tx_len_nxt    = tx_len_r;
    tx_j_nxt      = tx_j_r;
    ord_we        = 1'b0;
    ord_waddr     = head_r;
    ord_wdata     = free_idx;
    meta_we       = 1'b0;
    meta_waddr    = free_idx;
    meta_wdata.len     = LEN_W'(in_item.packet_length);
    meta_wdata.mac     = in_item.mac_address;
    meta_wdata.station = in_item.station_id;
    meta_re       = 1'b0;
    meta_raddr    = ord_rd;
    pay_we        = 1'b0;
    pay_waddr     = pay_addr(fill_phys_r, fill_pos_r);
    pay_wdata     = in_item.payload_byte;
    pay_re        = 1'b0;
    pay_raddr     = pay_addr(cur_phys_r, tx_j_r);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt   = 1'b0;
          state_nxt = ST_RESP;
          unique case (in_item.kind)
            KIND_NORMAL, KIND_PRIORITY: begin
              if (hdr_ok) begin
                acc_nxt  = 1'b1;
                ord_we   = 1'b1;
                meta_we  = 1'b1;
                if (in_item.kind == KIND_PRIORITY) begin
                  head_nxt  = ring_dec(head_r);
                  ord_waddr = ring_dec(head_r);
                end else begin
                  ord_waddr = ring_add(head_r, count_r);
                end
                used_nxt[free_idx] = 1'b1;
                count_nxt     = count_r + 1'b1;
                fill_phys_nxt = free_idx;
                fill_pos_nxt  = '0;
                fill_left_nxt = LEN_W'(in_item.packet_length);
              end
            end
            KIND_PAYLOAD: begin
              if (fill_left_r != '0) begin
                acc_nxt       = 1'b1;
                pay_we        = 1'b1;
                fill_pos_nxt  = fill_pos_r + 1'b1;
                fill_left_nxt = fill_left_r - 1'b1;
              end
            end
            KIND_PURGE: begin
              pst_nxt   = in_item.station_id;
              pi_nxt    = '0;
              kept_nxt  = '0;
              state_nxt = ST_P_RD;
            end
            KIND_SEND: begin
              if ((count_r != '0) && in_item.link_ready && !head_busy) begin
                // pop at once, the slot is only read until the send ends
                meta_re      = 1'b1;
                cur_phys_nxt = ord_rd;
                used_nxt[ord_rd] = 1'b0;
                head_nxt     = ring_add(head_r, CNT_W'(1));
                count_nxt    = count_r - 1'b1;
                state_nxt    = ST_S_META;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        if (res_taken) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_P_RD: begin
        if (pi_r == count_r) begin
          count_nxt = kept_r;
          acc_nxt   = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          meta_re      = 1'b1;
          cur_phys_nxt = ord_rd;
          state_nxt    = ST_P_CMP;
        end
      end
      ST_P_CMP: begin
        if (meta_rdata.station != pst_r) begin
          // keep: pack behind the head, the fill follows the physical slot
          ord_we    = 1'b1;
          ord_waddr = ring_add(head_r, kept_r);
          ord_wdata = cur_phys_r;
          kept_nxt  = kept_r + 1'b1;
        end else begin
          used_nxt[cur_phys_r] = 1'b0;
          if ((fill_left_r != '0) && (fill_phys_r == cur_phys_r)) begin
            fill_left_nxt = '0;
          end
        end
        pi_nxt    = pi_r + 1'b1;
        state_nxt = ST_P_RD;
      end
      ST_S_META: begin
        tx_st_nxt  = meta_rdata.station;
        tx_mac_nxt = meta_rdata.mac;
        tx_len_nxt = meta_rdata.len;
        tx_j_nxt   = '0;
        state_nxt  = ST_S_RD;
      end
      ST_S_RD: begin
        pay_re    = 1'b1;
        state_nxt = ST_S_OUT;
      end
      ST_S_OUT: begin
        if (res_taken) begin
          if (tx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            tx_j_nxt  = tx_j_r + 1'b1;
            state_nxt = ST_S_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res              = '0;
    res.entries_held = 4'(count_r);
    res.result_kind  = RKIND_STATUS;
    res.accepted     = acc_r;
    if (state_r == ST_S_OUT) begin
      res.result_kind = RKIND_BYTE;
      res.accepted    = 1'b1;
      res.out_station = tx_st_r;
      res.out_mac     = tx_mac_r;
      res.out_byte    = pay_rdata;
      res.last_byte   = tx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      used_r      <= '0;
      fill_phys_r <= '0;
      fill_pos_r  <= '0;
      fill_left_r <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      fill_phys_r <= fill_phys_nxt;
      fill_pos_r  <= fill_pos_nxt;
      fill_left_r <= fill_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    pst_r      <= pst_nxt;
    pi_r       <= pi_nxt;
    kept_r     <= kept_nxt;
    cur_phys_r <= cur_phys_nxt;
    tx_st_r    <= tx_st_nxt;
    tx_mac_r   <= tx_mac_nxt;
    tx_len_r   <= tx_len_nxt;
    tx_j_r     <= tx_j_nxt;
    if (ord_we) begin
      order_r[ord_waddr] <= ord_wdata;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_used_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(used_r) == int'(count_r)))
    else $error("slot usage mask disagrees with entry count");

  a_fill_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_left_r != '0) |-> used_r[fill_phys_r])
    else $error("pending fill targets a free slot");

  a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_left_r != '0) |-> ((SUM_W + LEN_W)'(fill_pos_r) + (SUM_W + LEN_W)'(fill_left_r)
                             <= (SUM_W + LEN_W)'(MAX_PACKET)))
    else $error("fill position runs past slot size");

  a_purge_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P_CMP) |-> (kept_r <= pi_r))
    else $error("purge packing overtook the scan");

endmodule

`default_nettype wire

### rtl/priority_packet_ring_queue.sv
`default_nettype none

// channel | direction | tdata (low bit up)                               | tuser | tlast
// in_     | slave     | station_id, mac_address, packet_length,          | kind  | -
//         |           | payload_byte, link_ready, zero fill to 80 bits   |       |
// out_    | master    | accepted, out_station, out_mac, out_byte,        | result| last_byte
//         |           | entries_held, zero fill to 72 bits               | _kind |
//
// one word is taken at a time; headers, payload and unknown kinds get a status result
// a purge scans the queue with one metadata read per entry
// a send reads the payload memory once per byte
// rst_n is synchronous, active low; it clears pointers, counts and the slot usage mask,
// the packet memories are not cleared
// a stalled out_tready holds the output register and the sequencer waits behind it;
// in_tready is high whenever the sequencer is idle, even if a result still waits
module priority_packet_ring_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // station_id[7:0], mac_address[55:8], packet_length[65:56], payload_byte[73:66],
  // link_ready[74], zero [79:75]
  input  wire logic [79:0] in_tdata,
  // kind[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // accepted[0], out_station[8:1], out_mac[56:9], out_byte[64:57],
  // entries_held[68:65], zero [71:69]
  output logic [71:0]      out_tdata,
  // result_kind[0]
  output logic             out_tuser,
  output logic             out_tlast
);

  import ppq_pkg::*;

  item_t             in_item;
  res_t              res;
  logic              res_valid;
  logic              res_ready;

  // metadata memory, one word per physical slot
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr;
  meta_t             meta_wdata;
  logic              meta_re;
  logic [IDX_W-1:0]  meta_raddr;
  meta_t             meta_rdata;

  // payload memory, one slot of bytes per physical slot
  logic              pay_we;
  logic [ADDR_W-1:0] pay_waddr;
  logic [7:0]        pay_wdata;
  logic              pay_re;
  logic [ADDR_W-1:0] pay_raddr;
  logic [7:0]        pay_rdata;

  // output register
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  // unpack the input word
  assign in_item.kind          = in_tuser;
  assign in_item.station_id    = in_tdata[7:0];
  assign in_item.mac_address   = in_tdata[55:8];
  assign in_item.packet_length = in_tdata[65:56];
  assign in_item.payload_byte  = in_tdata[73:66];
  assign in_item.link_ready    = in_tdata[74];

  ppq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .meta_re    (meta_re),
    .meta_raddr (meta_raddr),
    .meta_rdata (meta_rdata),
    .pay_we     (pay_we),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (pay_wdata),
    .pay_re     (pay_re),
    .pay_raddr  (pay_raddr),
    .pay_rdata  (pay_rdata)
  );

  ppq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (META_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  ppq_ram #(
    .DEPTH (QUEUE_DEPTH * MAX_PACKET),
    .WIDTH (8)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  // the output register loads when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.result_kind;
  assign out_tlast  = out_res_r.last_byte;
  assign out_tdata  = {3'b000, out_res_r.entries_held, out_res_r.out_byte,
                       out_res_r.out_mac, out_res_r.out_station, out_res_r.accepted};

endmodule

`default_nettype wire
